>>> rtl/ple_pkg.sv
// ----------------------------------------------------------------------------
// ple_pkg: shared codes for the positional list engine
// Command codes, status codes and the fixed field widths of the command and
// result beats.
// ----------------------------------------------------------------------------
package ple_pkg;

  localparam int unsigned OP_W    = 3;
  localparam int unsigned POS_W   = 7;
  localparam int unsigned VAL_W   = 32;
  localparam int unsigned STAT_W  = 2;

  localparam logic [OP_W-1:0] OP_APPEND = 3'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 3'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 3'd2;
  localparam logic [OP_W-1:0] OP_GET    = 3'd3;
  localparam logic [OP_W-1:0] OP_SET    = 3'd4;
  localparam logic [OP_W-1:0] OP_SEARCH = 3'd5;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd6;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  localparam logic [POS_W-1:0] FOUND_NONE = 7'h7f;

endpackage

>>> rtl/ple_store.sv
// ----------------------------------------------------------------------------
// ple_store: entry storage of the positional list engine
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ple_store #(
  parameter int unsigned Depth = 64,
  parameter int unsigned Width = 32,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/positional_list_engine_core.sv
// ----------------------------------------------------------------------------
// positional_list_engine_core: fixed-capacity ordered list of data words
// Append, insert, remove, get, set, search and clear on a list kept in a
// single-port-write, registered-read memory, walked one entry per cycle.
// ----------------------------------------------------------------------------
// A command beat is taken when start is high and busy is low; its result is
// shown for exactly one cycle with done_o high and cannot be held off.
// With n entries held and target position p: append, set, clear, insert at
// the end, search on an empty list and every error finish from idle; get
// reads entry p; remove walks entries p to n-1; insert in the middle walks
// n-1 down to p, then writes the word; search stops at the first match.
// The memory gives one read and one write per cycle, so moving or
// comparing entries goes one entry per cycle through the read port.
// ----------------------------------------------------------------------------
module positional_list_engine_core #(
  parameter int unsigned CAPACITY   = 64,
  parameter int unsigned WORD_WIDTH = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic [ple_pkg::OP_W-1:0]            op_i,
  input  logic [ple_pkg::POS_W-1:0]           position_i,
  input  logic [ple_pkg::VAL_W-1:0]           value_i,
  output logic                                done_o,
  output logic [ple_pkg::STAT_W-1:0]          status_o,
  output logic [ple_pkg::VAL_W-1:0]           read_value_o,
  output logic signed [ple_pkg::POS_W-1:0]    found_position_o,
  output logic [ple_pkg::POS_W-1:0]           entry_count_o
);

  localparam int unsigned IdxW = $clog2(CAPACITY);
  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned CmpW = (CntW > ple_pkg::POS_W) ? CntW : ple_pkg::POS_W;
  localparam int unsigned StW  = (WORD_WIDTH < ple_pkg::VAL_W) ? WORD_WIDTH
                                                               : ple_pkg::VAL_W;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_FINAL = 2'd2;

  logic [1:0]                   state_q, state_d;
  logic [CntW-1:0]              fill_q, fill_d;
  logic                         issue_q, issue_d;
  logic                         rvalid_q, rvalid_d;
  logic                         rlast_q, rlast_d;
  logic                         done_q, done_d;
  logic [ple_pkg::OP_W-1:0]     mode_q, mode_d;
  logic [IdxW-1:0]              ptr_q, ptr_d;
  logic [IdxW-1:0]              end_q, end_d;
  logic [IdxW-1:0]              raddr_q, raddr_d;
  logic [IdxW-1:0]              pos_q, pos_d;
  logic [StW-1:0]               val_q, val_d;
  logic [ple_pkg::STAT_W-1:0]   status_q, status_d;
  logic [ple_pkg::VAL_W-1:0]    rdval_q, rdval_d;
  logic [ple_pkg::POS_W-1:0]    found_q, found_d;

  logic                         we;
  logic [IdxW-1:0]              waddr;
  logic [StW-1:0]               wdata;
  logic [StW-1:0]               rdata;

  logic                         accept;
  logic                         is_full;
  logic                         past_end;
  logic                         not_held;
  logic [IdxW-1:0]              pos_idx;
  logic [IdxW-1:0]              fill_idx;
  logic [StW-1:0]               val_in;

  assign busy     = (state_q != S_IDLE);
  assign accept   = start && !busy;
  assign is_full  = (fill_q == CntW'(CAPACITY));
  assign past_end = (CmpW'(position_i) > CmpW'(fill_q));
  assign not_held = (CmpW'(position_i) >= CmpW'(fill_q));
  assign pos_idx  = IdxW'(position_i);
  assign fill_idx = IdxW'(fill_q);
  assign val_in   = value_i[StW-1:0];

  ple_store #(
    .Depth (CAPACITY),
    .Width (StW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (ptr_q),
    .rdata_o (rdata)
  );

  always_comb begin
    state_d  = state_q;
    fill_d   = fill_q;
    issue_d  = issue_q;
    rvalid_d = 1'b0;
    rlast_d  = rlast_q;
    done_d   = 1'b0;
    mode_d   = mode_q;
    ptr_d    = ptr_q;
    end_d    = end_q;
    raddr_d  = raddr_q;
    pos_d    = pos_q;
    val_d    = val_q;
    status_d = status_q;
    rdval_d  = rdval_q;
    found_d  = found_q;
    we       = 1'b0;
    waddr    = fill_idx;
    wdata    = val_in;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          done_d   = 1'b1;
          status_d = ple_pkg::ST_OK;
          rdval_d  = '0;
          found_d  = ple_pkg::FOUND_NONE;
          mode_d   = op_i;
          pos_d    = pos_idx;
          val_d    = val_in;
          case (op_i)
            ple_pkg::OP_APPEND: begin
              if (is_full) begin
                status_d = ple_pkg::ST_FULL;
              end else begin
                we     = 1'b1;
                waddr  = fill_idx;
                fill_d = fill_q + CntW'(1);
              end
            end
            ple_pkg::OP_INSERT: begin
              if (past_end) begin
                status_d = ple_pkg::ST_RANGE;
              end else if (is_full) begin
                status_d = ple_pkg::ST_FULL;
              end else if (CmpW'(position_i) == CmpW'(fill_q)) begin
                we     = 1'b1;
                waddr  = fill_idx;
                fill_d = fill_q + CntW'(1);
              end else begin
                done_d  = 1'b0;
                state_d = S_SCAN;
                issue_d = 1'b1;
                ptr_d   = IdxW'(fill_q - CntW'(1));
                end_d   = pos_idx;
              end
            end
            ple_pkg::OP_REMOVE, ple_pkg::OP_GET: begin
              if (not_held) begin
                status_d = ple_pkg::ST_RANGE;
              end else begin
                done_d  = 1'b0;
                state_d = S_SCAN;
                issue_d = 1'b1;
                ptr_d   = pos_idx;
                end_d   = (op_i == ple_pkg::OP_GET) ? pos_idx
                                                    : IdxW'(fill_q - CntW'(1));
              end
            end
            ple_pkg::OP_SET: begin
              if (not_held) begin
                status_d = ple_pkg::ST_RANGE;
              end else begin
                we    = 1'b1;
                waddr = pos_idx;
              end
            end
            ple_pkg::OP_SEARCH: begin
              if (fill_q != '0) begin
                done_d  = 1'b0;
                state_d = S_SCAN;
                issue_d = 1'b1;
                ptr_d   = '0;
                end_d   = IdxW'(fill_q - CntW'(1));
              end
            end
            ple_pkg::OP_CLEAR: begin
              fill_d = '0;
            end
            default: begin
            end
          endcase
        end
      end

      S_SCAN: begin
        if (issue_q) begin
          rvalid_d = 1'b1;
          raddr_d  = ptr_q;
          rlast_d  = (ptr_q == end_q);
          issue_d  = (ptr_q != end_q);
          ptr_d    = (mode_q == ple_pkg::OP_INSERT) ? ptr_q - IdxW'(1)
                                                    : ptr_q + IdxW'(1);
        end
        if (rvalid_q) begin
          case (mode_q)
            ple_pkg::OP_INSERT: begin
              we    = 1'b1;
              waddr = raddr_q + IdxW'(1);
              wdata = rdata;
              if (rlast_q) begin
                state_d = S_FINAL;
              end
            end
            ple_pkg::OP_REMOVE: begin
              if (raddr_q == pos_q) begin
                rdval_d = ple_pkg::VAL_W'(rdata);
              end else begin
                we    = 1'b1;
                waddr = raddr_q - IdxW'(1);
                wdata = rdata;
              end
              if (rlast_q) begin
                fill_d  = fill_q - CntW'(1);
                done_d  = 1'b1;
                state_d = S_IDLE;
              end
            end
            ple_pkg::OP_GET: begin
              rdval_d = ple_pkg::VAL_W'(rdata);
              done_d  = 1'b1;
              state_d = S_IDLE;
            end
            ple_pkg::OP_SEARCH: begin
              if (rdata == val_q) begin
                found_d = ple_pkg::POS_W'(raddr_q);
                done_d  = 1'b1;
                state_d = S_IDLE;
              end else if (rlast_q) begin
                done_d  = 1'b1;
                state_d = S_IDLE;
              end
            end
            default: begin
              done_d  = 1'b1;
              state_d = S_IDLE;
            end
          endcase
          if (state_d == S_IDLE) begin
            issue_d = 1'b0;
          end
        end
      end

      S_FINAL: begin
        we      = 1'b1;
        waddr   = pos_q;
        wdata   = val_q;
        fill_d  = fill_q + CntW'(1);
        done_d  = 1'b1;
        state_d = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
        issue_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      fill_q   <= '0;
      issue_q  <= 1'b0;
      rvalid_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      fill_q   <= fill_d;
      issue_q  <= issue_d;
      rvalid_q <= rvalid_d;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rlast_q  <= rlast_d;
    mode_q   <= mode_d;
    ptr_q    <= ptr_d;
    end_q    <= end_d;
    raddr_q  <= raddr_d;
    pos_q    <= pos_d;
    val_q    <= val_d;
    status_q <= status_d;
    rdval_q  <= rdval_d;
    found_q  <= found_d;
  end

  assign done_o           = done_q;
  assign status_o         = status_q;
  assign read_value_o     = rdval_q;
  assign found_position_o = $signed(found_q);
  assign entry_count_o    = ple_pkg::POS_W'(fill_q);

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CntW'(CAPACITY))
    else $error("entry count above capacity");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && op_i == ple_pkg::OP_CLEAR |=> fill_q == '0 && done_q)
    else $error("clear did not empty the list");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && status_q == ple_pkg::ST_FULL |-> is_full)
    else $error("full status while list not full");

  a_found_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && found_q != ple_pkg::FOUND_NONE |-> status_q == ple_pkg::ST_OK && rdval_q == '0)
    else $error("search hit with bad status or data");

  a_no_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_IDLE |-> !done_q)
    else $error("result beat while walking entries");

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for positional_list_engine_core
// A table of directed commands covers the empty list, the full list, range
// and full errors, the unused code and the extreme field values. Random
// traffic follows, steered to fill and empty the list while drawing words
// from a small pool so searches hit. Every result beat is checked against
// a model of the list kept here or, for pinned steps, the result in the table.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned CAPACITY = 64;
  localparam int unsigned N_RANDOM = 1350;
  localparam logic [ple_pkg::OP_W-1:0] OP_UNUSED = 3'd7;

  typedef struct packed {
    logic [ple_pkg::STAT_W-1:0] status;
    logic [ple_pkg::VAL_W-1:0]  read_value;
    logic [ple_pkg::POS_W-1:0]  found;
    logic [ple_pkg::POS_W-1:0]  count;
  } list_result_t;

  typedef struct packed {
    logic [ple_pkg::OP_W-1:0]  op;
    logic [ple_pkg::POS_W-1:0] pos;
    logic [ple_pkg::VAL_W-1:0] val;
    logic [ple_pkg::POS_W-1:0] reps;
    logic                      pinned;
    list_result_t              res;
  } list_step_t;

  logic                              clk_i            = 1'b0;
  logic                              rst_ni           = 1'b0;
  logic                              start            = 1'b0;
  logic                              busy;
  logic [ple_pkg::OP_W-1:0]          op_i             = ple_pkg::OP_CLEAR;
  logic [ple_pkg::POS_W-1:0]         position_i       = '0;
  logic [ple_pkg::VAL_W-1:0]         value_i          = '0;
  logic                              done_o;
  logic [ple_pkg::STAT_W-1:0]        status_o;
  logic [ple_pkg::VAL_W-1:0]         read_value_o;
  logic signed [ple_pkg::POS_W-1:0]  found_position_o;
  logic [ple_pkg::POS_W-1:0]         entry_count_o;

  logic                              cmd_pinned       = 1'b0;
  list_result_t                      cmd_pinned_res   = '0;

  logic [ple_pkg::VAL_W-1:0]         list_words [CAPACITY];
  int unsigned                       list_fill        = 0;
  list_result_t                      pending_results [$];
  int unsigned                       n_errors         = 0;
  logic [ple_pkg::VAL_W-1:0]         word_pool [8];

  list_step_t bench_steps [30] = '{
    '{ple_pkg::OP_GET,    7'd0,   32'h0,        7'd1,  1'b1,
      '{ple_pkg::ST_RANGE, 32'h0, ple_pkg::FOUND_NONE, 7'd0}},
    '{ple_pkg::OP_REMOVE, 7'd0,   32'h0,        7'd1,  1'b1,
      '{ple_pkg::ST_RANGE, 32'h0, ple_pkg::FOUND_NONE, 7'd0}},
    '{ple_pkg::OP_SET,    7'd0,   32'h1,        7'd1,  1'b1,
      '{ple_pkg::ST_RANGE, 32'h0, ple_pkg::FOUND_NONE, 7'd0}},
    '{ple_pkg::OP_SEARCH, 7'd0,   32'h0,        7'd1,  1'b1,
      '{ple_pkg::ST_OK,    32'h0, ple_pkg::FOUND_NONE, 7'd0}},
    '{ple_pkg::OP_INSERT, 7'd1,   32'h1,        7'd1,  1'b1,
      '{ple_pkg::ST_RANGE, 32'h0, ple_pkg::FOUND_NONE, 7'd0}},
    '{ple_pkg::OP_APPEND, 7'd0,   32'hFFFFFFFF, 7'd1,  1'b1,
      '{ple_pkg::ST_OK,    32'h0, ple_pkg::FOUND_NONE, 7'd1}},
    '{ple_pkg::OP_APPEND, 7'd0,   32'h0,        7'd1,  1'b1,
      '{ple_pkg::ST_OK,    32'h0, ple_pkg::FOUND_NONE, 7'd2}},
    '{ple_pkg::OP_INSERT, 7'd0,   32'hA5A5A5A5, 7'd1,  1'b1,
      '{ple_pkg::ST_OK,    32'h0, ple_pkg::FOUND_NONE, 7'd3}},
    '{ple_pkg::OP_INSERT, 7'd3,   32'h5A5A5A5A, 7'd1,  1'b1,
      '{ple_pkg::ST_OK,    32'h0, ple_pkg::FOUND_NONE, 7'd4}},
    '{ple_pkg::OP_INSERT, 7'd2,   32'h12345678, 7'd1,  1'b1,
      '{ple_pkg::ST_OK,    32'h0, ple_pkg::FOUND_NONE, 7'd5}},
    '{ple_pkg::OP_GET,    7'd4,   32'h0,        7'd1,  1'b1,
      '{ple_pkg::ST_OK, 32'h5A5A5A5A, ple_pkg::FOUND_NONE, 7'd5}},
    '{ple_pkg::OP_SEARCH, 7'd0,   32'h0,        7'd1,  1'b1,
      '{ple_pkg::ST_OK,    32'h0, 7'd3,       7'd5}},
    '{ple_pkg::OP_SEARCH, 7'd0,   32'hDEADBEEF, 7'd1,  1'b1,
      '{ple_pkg::ST_OK,    32'h0, ple_pkg::FOUND_NONE, 7'd5}},
    '{ple_pkg::OP_SET,    7'd1,   32'h80000001, 7'd1,  1'b1,
      '{ple_pkg::ST_OK,    32'h0, ple_pkg::FOUND_NONE, 7'd5}},
    '{ple_pkg::OP_GET,    7'd1,   32'h0,        7'd1,  1'b1,
      '{ple_pkg::ST_OK, 32'h80000001, ple_pkg::FOUND_NONE, 7'd5}},
    '{ple_pkg::OP_GET,    7'd127, 32'h0,        7'd1,  1'b1,
      '{ple_pkg::ST_RANGE, 32'h0, ple_pkg::FOUND_NONE, 7'd5}},
    '{ple_pkg::OP_REMOVE, 7'd5,   32'h0,        7'd1,  1'b1,
      '{ple_pkg::ST_RANGE, 32'h0, ple_pkg::FOUND_NONE, 7'd5}},
    '{ple_pkg::OP_REMOVE, 7'd0,   32'h0,        7'd1,  1'b1,
      '{ple_pkg::ST_OK, 32'hA5A5A5A5, ple_pkg::FOUND_NONE, 7'd4}},
    '{OP_UNUSED,          7'd127, 32'hFFFFFFFF, 7'd1,  1'b1,
      '{ple_pkg::ST_OK,    32'h0, ple_pkg::FOUND_NONE, 7'd4}},
    '{ple_pkg::OP_CLEAR,  7'd0,   32'h0,        7'd1,  1'b1,
      '{ple_pkg::ST_OK,    32'h0, ple_pkg::FOUND_NONE, 7'd0}},
    '{ple_pkg::OP_APPEND, 7'd0,   32'h100,      7'd64, 1'b0, '0},
    '{ple_pkg::OP_SEARCH, 7'd0,   32'h13F,      7'd1,  1'b1,
      '{ple_pkg::ST_OK,    32'h0, 7'd63,      7'd64}},
    '{ple_pkg::OP_APPEND, 7'd0,   32'h0,        7'd1,  1'b1,
      '{ple_pkg::ST_FULL,  32'h0, ple_pkg::FOUND_NONE, 7'd64}},
    '{ple_pkg::OP_INSERT, 7'd65,  32'h0,        7'd1,  1'b1,
      '{ple_pkg::ST_RANGE, 32'h0, ple_pkg::FOUND_NONE, 7'd64}},
    '{ple_pkg::OP_INSERT, 7'd64,  32'h0,        7'd1,  1'b1,
      '{ple_pkg::ST_FULL,  32'h0, ple_pkg::FOUND_NONE, 7'd64}},
    '{ple_pkg::OP_INSERT, 7'd0,   32'h0,        7'd1,  1'b1,
      '{ple_pkg::ST_FULL,  32'h0, ple_pkg::FOUND_NONE, 7'd64}},
    '{ple_pkg::OP_REMOVE, 7'd63,  32'h0,        7'd1,  1'b1,
      '{ple_pkg::ST_OK,    32'h13F, ple_pkg::FOUND_NONE, 7'd63}},
    '{ple_pkg::OP_GET,    7'd63,  32'h0,        7'd1,  1'b1,
      '{ple_pkg::ST_RANGE, 32'h0, ple_pkg::FOUND_NONE, 7'd63}},
    '{ple_pkg::OP_INSERT, 7'd20,  32'h7,        7'd1,  1'b0, '0},
    '{ple_pkg::OP_CLEAR,  7'd0,   32'h0,        7'd1,  1'b1,
      '{ple_pkg::ST_OK,    32'h0, ple_pkg::FOUND_NONE, 7'd0}}
  };

  positional_list_engine_core u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .op_i             (op_i),
    .position_i       (position_i),
    .value_i          (value_i),
    .done_o           (done_o),
    .status_o         (status_o),
    .read_value_o     (read_value_o),
    .found_position_o (found_position_o),
    .entry_count_o    (entry_count_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // list model: applies one command and returns its result beat
  function automatic list_result_t apply_list_cmd(input logic [ple_pkg::OP_W-1:0] op,
                                                  input logic [ple_pkg::POS_W-1:0] pos,
                                                  input logic [ple_pkg::VAL_W-1:0] val);
    list_result_t res;
    res = '{ple_pkg::ST_OK, '0, ple_pkg::FOUND_NONE, '0};
    case (op)
      ple_pkg::OP_APPEND: begin
        if (list_fill >= CAPACITY) res.status = ple_pkg::ST_FULL;
        else begin
          list_words[list_fill] = val;
          list_fill++;
        end
      end
      ple_pkg::OP_INSERT: begin
        if (pos > list_fill) res.status = ple_pkg::ST_RANGE;
        else if (list_fill >= CAPACITY) res.status = ple_pkg::ST_FULL;
        else begin
          for (int i = list_fill; i > pos; i--) list_words[i] = list_words[i-1];
          list_words[pos] = val;
          list_fill++;
        end
      end
      ple_pkg::OP_REMOVE: begin
        if (pos >= list_fill) res.status = ple_pkg::ST_RANGE;
        else begin
          res.read_value = list_words[pos];
          for (int i = pos; i + 1 < list_fill; i++) list_words[i] = list_words[i+1];
          list_fill--;
        end
      end
      ple_pkg::OP_GET: begin
        if (pos >= list_fill) res.status = ple_pkg::ST_RANGE;
        else res.read_value = list_words[pos];
      end
      ple_pkg::OP_SET: begin
        if (pos >= list_fill) res.status = ple_pkg::ST_RANGE;
        else list_words[pos] = val;
      end
      ple_pkg::OP_SEARCH: begin
        for (int i = int'(list_fill) - 1; i >= 0; i--) begin
          if (list_words[i] == val) res.found = ple_pkg::POS_W'(i);
        end
      end
      ple_pkg::OP_CLEAR: list_fill = 0;
      default: ;
    endcase
    res.count = ple_pkg::POS_W'(list_fill);
    return res;
  endfunction

  task automatic check_field(input string name, input logic [ple_pkg::VAL_W-1:0] want,
                             input logic [ple_pkg::VAL_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      n_errors++;
    end
  endtask

  // command beats taken, result beats checked
  always @(posedge clk_i) begin
    list_result_t pred;
    list_result_t want;
    if (rst_ni) begin
      if (start && !busy) begin
        pred = apply_list_cmd(op_i, position_i, value_i);
        pending_results.push_back(cmd_pinned ? cmd_pinned_res : pred);
      end
      if (done_o) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result beat, status %h count %h", $time, status_o,
                   entry_count_o);
          n_errors++;
        end else begin
          want = pending_results.pop_front();
          check_field("status", ple_pkg::VAL_W'(want.status), ple_pkg::VAL_W'(status_o));
          check_field("read_value", want.read_value, read_value_o);
          check_field("found_position", ple_pkg::VAL_W'(want.found),
                      ple_pkg::VAL_W'($unsigned(found_position_o)));
          check_field("entry_count", ple_pkg::VAL_W'(want.count),
                      ple_pkg::VAL_W'(entry_count_o));
        end
      end
    end
  end

  task automatic issue_cmd(input logic [ple_pkg::OP_W-1:0] op,
                           input logic [ple_pkg::POS_W-1:0] pos,
                           input logic [ple_pkg::VAL_W-1:0] val, input logic pinned,
                           input list_result_t pinned_res);
    start          <= 1'b1;
    op_i           <= op;
    position_i     <= pos;
    value_i        <= val;
    cmd_pinned     <= pinned;
    cmd_pinned_res <= pinned_res;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic maybe_pause(input bit allow);
    if (allow && $urandom_range(0, 99) < 20) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    logic [ple_pkg::OP_W-1:0]  op;
    logic [ple_pkg::POS_W-1:0] pos;
    logic [ple_pkg::VAL_W-1:0] val;
    int unsigned               fill_goal;
    int unsigned               fill_now;
    int unsigned               r;
    bit                        grow;

    word_pool[0] = '0;
    word_pool[1] = '1;
    for (int i = 2; i < 8; i++) word_pool[i] = $urandom;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (bench_steps[s]) begin
      for (int k = 0; k < bench_steps[s].reps; k++) begin
        maybe_pause(1'b1);
        issue_cmd(bench_steps[s].op, bench_steps[s].pos,
                  bench_steps[s].val + ple_pkg::VAL_W'(k),
                  bench_steps[s].pinned, bench_steps[s].res);
      end
    end
    wait_drained();

    fill_goal = 0;
    for (int k = 0; k < N_RANDOM; k++) begin
      if (k % 40 == 0) begin
        r = $urandom_range(0, 99);
        fill_goal = (r < 25) ? CAPACITY : (r < 40) ? 0 : $urandom_range(1, CAPACITY - 1);
      end
      if (k > 0 && k % 300 == 0) wait_drained();
      else maybe_pause(k < 500 || k >= 800);

      fill_now = list_fill;
      grow = (fill_now < fill_goal) || (fill_goal == CAPACITY);
      r = $urandom_range(0, 99);
      if (r < (grow ? 35 : 10)) op = ple_pkg::OP_APPEND;
      else if (r < (grow ? 60 : 20)) op = ple_pkg::OP_INSERT;
      else if (r < (grow ? 68 : 55)) op = ple_pkg::OP_REMOVE;
      else if (r < (grow ? 79 : 68)) op = ple_pkg::OP_GET;
      else if (r < (grow ? 87 : 78)) op = ple_pkg::OP_SET;
      else if (r < 97) op = ple_pkg::OP_SEARCH;
      else if (r < 98) op = ple_pkg::OP_CLEAR;
      else op = OP_UNUSED;

      if ($urandom_range(0, 99) < 15) pos = ple_pkg::POS_W'($urandom_range(0, 127));
      else if (op == ple_pkg::OP_INSERT) pos = ple_pkg::POS_W'($urandom_range(0, fill_now));
      else if (fill_now == 0) pos = '0;
      else pos = ple_pkg::POS_W'($urandom_range(0, fill_now - 1));

      if ($urandom_range(0, 99) < ((op == ple_pkg::OP_SEARCH) ? 70 : 60))
        val = word_pool[$urandom_range(0, 7)];
      else val = $urandom;

      issue_cmd(op, pos, val, 1'b0, '0);
    end

    wait_drained();
    repeat (80) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
